// ===== src/lwif_pkg.sv =====
package lwif_pkg;

	// Default sizing
	localparam int DEF_MAX_WIDTH  = 1024;
	localparam int DEF_MAX_RADIUS = 2;

	// Field and register widths
	localparam int PIX_W   = 8;
	localparam int CHANS   = 3;
	localparam int CFG_W   = 11;
	localparam int RAD_W   = 2;
	localparam int IDX_W   = 2;

	// Register indexes
	localparam logic [IDX_W-1:0] REG_IMAGE_WIDTH   = 2'd0;
	localparam logic [IDX_W-1:0] REG_IMAGE_HEIGHT  = 2'd1;
	localparam logic [IDX_W-1:0] REG_WINDOW_RADIUS = 2'd2;

	// Reset values of the registers
	localparam logic [CFG_W-1:0] RST_IMAGE_WIDTH   = 11'd1024;
	localparam logic [CFG_W-1:0] RST_IMAGE_HEIGHT  = 11'd1024;
	localparam logic [RAD_W-1:0] RST_WINDOW_RADIUS = 2'd2;

	// Steps of the restoring divider (quotient is never above 255)
	localparam int DIV_STEPS = PIX_W;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_WAIT,
		ST_SQUARE,
		ST_DIVIDE,
		ST_DONE
	} lwif_state_t;

endpackage

// ===== src/lwif_ram.sv =====
module lwif_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 6144
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== src/local_window_illumination_filter.sv =====
// Local window illumination filter. RGB pixels arrive in raster order, one
// request per pixel; for each pixel the block takes, per channel, the maximum
// and minimum over a square window of radius window_radius (clipped at the
// image borders) and outputs (max-min)+min*min/max, or 0 where max is 0.
// Output lags input by radius rows plus radius pixels; after the last pixel of
// a frame, flush requests (or further pixels, whose data is dropped) drain one
// output each, and end_of_frame marks the last one. Pixels are kept in a ring
// of 2*MAX_RADIUS+2 rows in one single-port-read RAM. A request that produces
// no output is taken in the idle state and leaves it idle. A request that
// produces an output reads the window pixels, one per cycle through the RAM
// read port (25 reads for a full 5x5 window), then runs the wait, square and
// 8 divide steps of the per-channel restoring divider and waits for the receiver;
// no new request is taken meanwhile. A configuration write returns the
// frame position to the start; write registers only while idle.
module local_window_illumination_filter
	import lwif_pkg::*;
#(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_RADIUS = DEF_MAX_RADIUS
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_write,
	input  logic [lwif_pkg::IDX_W-1:0] cfg_index,
	input  logic [lwif_pkg::CFG_W-1:0] cfg_data,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [lwif_pkg::PIX_W-1:0] in_blue,
	input  logic [lwif_pkg::PIX_W-1:0] in_green,
	input  logic [lwif_pkg::PIX_W-1:0] in_red,
	input  logic                       is_flush,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [lwif_pkg::PIX_W-1:0] out_blue,
	output logic [lwif_pkg::PIX_W-1:0] out_green,
	output logic [lwif_pkg::PIX_W-1:0] out_red,
	output logic                       end_of_frame
);

	import lwif_pkg::*;

	localparam int RING   = 2 * MAX_RADIUS + 2;
	localparam int RGW    = $clog2(RING);
	localparam int DEPTH  = RING * MAX_WIDTH;
	localparam int AW     = $clog2(DEPTH);
	localparam int COLW   = $clog2(MAX_WIDTH);
	localparam int CW     = $clog2(MAX_WIDTH + 1);
	localparam int XW     = (CW > CFG_W) ? CW : CFG_W;
	localparam int RW     = $clog2(MAX_RADIUS + 1);
	localparam int RCW    = (RW > RAD_W) ? RW : RAD_W;
	localparam int LW     = COLW + CFG_W + 1;
	localparam int DATW   = CHANS * PIX_W;
	localparam int STW    = $clog2(DIV_STEPS + 1);

	// Configuration registers
	logic [CFG_W-1:0] width_q, height_q;
	logic [RAD_W-1:0] radius_q;

	// Effective configuration
	logic [XW-1:0]    w_eff;
	logic [CFG_W-1:0] h_eff;
	logic [RW-1:0]    r_eff;
	logic [LW-1:0]    delay;

	always_comb begin
		if (width_q == '0) begin
			w_eff = XW'(1);
		end else if (XW'(width_q) > XW'(MAX_WIDTH)) begin
			w_eff = XW'(MAX_WIDTH);
		end else begin
			w_eff = XW'(width_q);
		end
		h_eff = (height_q == '0) ? CFG_W'(1) : height_q;
		r_eff = (RCW'(radius_q) > RCW'(MAX_RADIUS)) ? RW'(MAX_RADIUS) : RW'(radius_q);
		delay = LW'(r_eff) * LW'(w_eff) + LW'(r_eff);
	end

	// Position state
	logic [CFG_W-1:0] in_row_q, out_row_q;
	logic [COLW-1:0]  in_col_q, out_col_q;
	logic [RGW-1:0]   in_ring_q, out_ring_q;
	logic [LW-1:0]    in_cnt_q, out_cnt_q;

	lwif_state_t state_q, state_d;

	// Request decode
	logic accept, store, emit, in_col_wrap, out_col_wrap, frame_end;
	logic [LW-1:0] pending;

	assign accept       = in_valid && in_ready;
	assign store        = (in_row_q < h_eff) && !is_flush;
	assign pending      = in_cnt_q + LW'(1) - out_cnt_q;
	assign emit         = store ? (pending > delay) : (in_row_q >= h_eff);
	assign in_col_wrap  = (XW'(in_col_q) + XW'(1)) >= w_eff;
	assign out_col_wrap = (XW'(out_col_q) + XW'(1)) >= w_eff;
	assign frame_end    = out_col_wrap && ((CFG_W + 1)'(out_row_q) + (CFG_W + 1)'(1)
		>= (CFG_W + 1)'(h_eff));

	// Window bounds of the output pixel
	logic [CFG_W-1:0] r0, r1;
	logic [COLW-1:0]  c0, c1;
	logic [RGW-1:0]   ring0;
	logic [RW-1:0]    roff;

	always_comb begin
		r0 = (out_row_q >= CFG_W'(r_eff)) ? out_row_q - CFG_W'(r_eff) : '0;
		r1 = ((CFG_W + 1)'(out_row_q) + (CFG_W + 1)'(r_eff) < (CFG_W + 1)'(h_eff)) ?
			out_row_q + CFG_W'(r_eff) : h_eff - CFG_W'(1);
		c0 = (out_col_q >= COLW'(r_eff)) ? out_col_q - COLW'(r_eff) : '0;
		c1 = (XW'(out_col_q) + XW'(r_eff) < w_eff) ?
			out_col_q + COLW'(r_eff) : COLW'(w_eff - XW'(1));
		roff  = RW'(out_row_q - r0);
		ring0 = (out_ring_q >= RGW'(roff)) ? out_ring_q - RGW'(roff) :
			out_ring_q + RGW'(RING) - RGW'(roff);
	end

	// Window scan registers
	logic [CFG_W-1:0] y_q, r1_q;
	logic [COLW-1:0]  x_q, c0_q, c1_q;
	logic [RGW-1:0]   ring_y_q;
	logic             eof_q;
	logic             scan_last;
	logic             rd_vld_s1;

	assign scan_last = (x_q == c1_q) && (y_q == r1_q);

	// Row store
	logic [AW-1:0]   waddr, raddr;
	logic [DATW-1:0] wdata, rdata;
	logic            we, rd_issue;

	assign waddr = AW'(in_ring_q) * AW'(MAX_WIDTH) + AW'(in_col_q);
	assign raddr = AW'(ring_y_q) * AW'(MAX_WIDTH) + AW'(x_q);
	assign wdata = {in_red, in_green, in_blue};
	assign we    = accept && store;

	lwif_ram #(
		.WIDTH(DATW),
		.DEPTH(DEPTH)
	) u_row_store (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	// Next state
	logic [STW-1:0] step_q;
	logic           out_load;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:   if (accept && emit) state_d = ST_READ;
			ST_READ:   if (scan_last) state_d = ST_WAIT;
			ST_WAIT:   state_d = ST_SQUARE;
			ST_SQUARE: state_d = ST_DIVIDE;
			ST_DIVIDE: if (step_q == STW'(DIV_STEPS - 1)) state_d = ST_DONE;
			ST_DONE:   if (!out_valid || out_ready) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// State outputs
	always_comb begin
		in_ready = 1'b0;
		rd_issue = 1'b0;
		out_load = 1'b0;
		case (state_q)
			ST_IDLE: in_ready = 1'b1;
			ST_READ: rd_issue = 1'b1;
			ST_DONE: out_load = !out_valid || out_ready;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Configuration and frame position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q    <= RST_IMAGE_WIDTH;
			height_q   <= RST_IMAGE_HEIGHT;
			radius_q   <= RST_WINDOW_RADIUS;
			in_row_q   <= '0;
			in_col_q   <= '0;
			in_ring_q  <= '0;
			in_cnt_q   <= '0;
			out_row_q  <= '0;
			out_col_q  <= '0;
			out_ring_q <= '0;
			out_cnt_q  <= '0;
		end else if (cfg_write && (cfg_index == REG_IMAGE_WIDTH ||
				cfg_index == REG_IMAGE_HEIGHT || cfg_index == REG_WINDOW_RADIUS)) begin
			case (cfg_index)
				REG_IMAGE_WIDTH:  width_q  <= cfg_data;
				REG_IMAGE_HEIGHT: height_q <= cfg_data;
				default:          radius_q <= cfg_data[RAD_W-1:0];
			endcase
			in_row_q   <= '0;
			in_col_q   <= '0;
			in_ring_q  <= '0;
			in_cnt_q   <= '0;
			out_row_q  <= '0;
			out_col_q  <= '0;
			out_ring_q <= '0;
			out_cnt_q  <= '0;
		end else if (accept) begin
			if (emit && frame_end) begin
				in_row_q   <= '0;
				in_col_q   <= '0;
				in_ring_q  <= '0;
				in_cnt_q   <= '0;
				out_row_q  <= '0;
				out_col_q  <= '0;
				out_ring_q <= '0;
				out_cnt_q  <= '0;
			end else begin
				if (store) begin
					in_cnt_q <= in_cnt_q + LW'(1);
					if (in_col_wrap) begin
						in_col_q  <= '0;
						in_row_q  <= in_row_q + CFG_W'(1);
						in_ring_q <= (in_ring_q == RGW'(RING - 1)) ? '0 : in_ring_q + RGW'(1);
					end else begin
						in_col_q <= in_col_q + COLW'(1);
					end
				end
				if (emit) begin
					out_cnt_q <= out_cnt_q + LW'(1);
					if (out_col_wrap) begin
						out_col_q  <= '0;
						out_row_q  <= out_row_q + CFG_W'(1);
						out_ring_q <= (out_ring_q == RGW'(RING - 1)) ? '0 :
							out_ring_q + RGW'(1);
					end else begin
						out_col_q <= out_col_q + COLW'(1);
					end
				end
			end
		end
	end

	// Window scan
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= rd_issue;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && emit) begin
			y_q      <= r0;
			r1_q     <= r1;
			x_q      <= c0;
			c0_q     <= c0;
			c1_q     <= c1;
			ring_y_q <= ring0;
			eof_q    <= frame_end;
		end else if (rd_issue && !scan_last) begin
			if (x_q == c1_q) begin
				x_q      <= c0_q;
				y_q      <= y_q + CFG_W'(1);
				ring_y_q <= (ring_y_q == RGW'(RING - 1)) ? '0 : ring_y_q + RGW'(1);
			end else begin
				x_q <= x_q + COLW'(1);
			end
		end
	end

	// Per-channel extrema, square and restoring division
	logic [PIX_W-1:0]   mx_q  [CHANS];
	logic [PIX_W-1:0]   mn_q  [CHANS];
	logic [PIX_W-1:0]   rem_q [CHANS];
	logic [PIX_W-1:0]   lo_q  [CHANS];
	logic [2*PIX_W-1:0] sq    [CHANS];
	logic [PIX_W:0]     trial [CHANS];
	logic [PIX_W-1:0]   res   [CHANS];

	always_comb begin
		for (int k = 0; k < CHANS; k++) begin
			sq[k]    = mn_q[k] * mn_q[k];
			trial[k] = {rem_q[k], lo_q[k][PIX_W-1]};
			res[k]   = (mx_q[k] == '0) ? '0 : (mx_q[k] - mn_q[k]) + lo_q[k];
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < CHANS; k++) begin
			if (accept && emit) begin
				mx_q[k] <= '0;
				mn_q[k] <= '1;
			end else if (rd_vld_s1) begin
				if (rdata[k*PIX_W +: PIX_W] > mx_q[k]) mx_q[k] <= rdata[k*PIX_W +: PIX_W];
				if (rdata[k*PIX_W +: PIX_W] < mn_q[k]) mn_q[k] <= rdata[k*PIX_W +: PIX_W];
			end
			if (state_q == ST_SQUARE) begin
				rem_q[k] <= sq[k][2*PIX_W-1:PIX_W];
				lo_q[k]  <= sq[k][PIX_W-1:0];
			end else if (state_q == ST_DIVIDE) begin
				if (trial[k] >= {1'b0, mx_q[k]}) begin
					rem_q[k] <= PIX_W'(trial[k] - {1'b0, mx_q[k]});
					lo_q[k]  <= {lo_q[k][PIX_W-2:0], 1'b1};
				end else begin
					rem_q[k] <= trial[k][PIX_W-1:0];
					lo_q[k]  <= {lo_q[k][PIX_W-2:0], 1'b0};
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
		end else if (state_q == ST_DIVIDE) begin
			step_q <= step_q + STW'(1);
		end else begin
			step_q <= '0;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (out_load) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_blue     <= res[0];
			out_green    <= res[1];
			out_red      <= res[2];
			end_of_frame <= eof_q;
		end
	end

`ifndef SYNTHESIS
	// Never more outputs than pixels received
	assert property (@(posedge clk) disable iff (!arst_n) out_cnt_q <= in_cnt_q)
		else $error("output count ahead of input count");

	// A scanned window always holds min no greater than max
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SQUARE |-> mn_q[0] <= mx_q[0] && mn_q[1] <= mx_q[1] &&
			mn_q[2] <= mx_q[2])
		else $error("window extrema inverted");

	// Reads stop once the scan reaches its last pixel
	assert property (@(posedge clk) disable iff (!arst_n)
		rd_issue && scan_last |=> !rd_issue)
		else $error("window scan overran");
`endif

endmodule
